### rtl/lfuc_pkg.sv
// Shared types and constants for the LFU cache with LRU tie break.
// No dependencies; imported by lfuc_cell, lfu_cache_lru_tiebreak and the testbench.
package lfuc_pkg;

  localparam int USES_W  = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};
  localparam logic [USES_W-1:0] USES_ONE = USES_W'(1);
  localparam logic [CFG_W-1:0]  CAP_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    WR_TOUCH = 2'b01,
    WR_LOAD  = 2'b10
  } wr_kind_t;

  typedef struct packed {
    logic     we;
    wr_kind_t kind;
    logic     upd_data;
  } wr_ctl_t;

  typedef struct packed {
    logic match;
    logic best_vld;
  } scan_flags_t;

endpackage

### rtl/lfuc_cell.sv
// One cache slot of the scan chain: holds key, data, use count and stamp.
// Folds its slot into the passing search word; depends on lfuc_pkg.
module lfuc_cell #(
  parameter int KEY_WIDTH  = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic [CNT_W-1:0]             fill_cnt,
  input  logic [KEY_WIDTH-1:0]         t_key,
  input  lfuc_pkg::scan_flags_t        t_flags,
  input  logic [IDX_W-1:0]             t_match_idx,
  input  logic [DATA_WIDTH-1:0]        t_match_data,
  input  logic [lfuc_pkg::USES_W-1:0]  t_best_uses,
  input  logic [lfuc_pkg::STAMP_W-1:0] t_best_stamp,
  input  logic [IDX_W-1:0]             t_best_idx,
  input  logic [KEY_WIDTH-1:0]         t_best_key,
  output logic [KEY_WIDTH-1:0]         o_key,
  output lfuc_pkg::scan_flags_t        o_flags,
  output logic [IDX_W-1:0]             o_match_idx,
  output logic [DATA_WIDTH-1:0]        o_match_data,
  output logic [lfuc_pkg::USES_W-1:0]  o_best_uses,
  output logic [lfuc_pkg::STAMP_W-1:0] o_best_stamp,
  output logic [IDX_W-1:0]             o_best_idx,
  output logic [KEY_WIDTH-1:0]         o_best_key,
  input  lfuc_pkg::wr_ctl_t            wr_ctl,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [KEY_WIDTH-1:0]         wr_key,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  input  logic [lfuc_pkg::STAMP_W-1:0] wr_stamp
);
  import lfuc_pkg::*;

  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [USES_W-1:0]     uses_r;
  logic [STAMP_W-1:0]    stamp_r;

  logic [KEY_WIDTH-1:0]  tok_key_r;
  scan_flags_t           tok_flags_r;
  logic [IDX_W-1:0]      tok_match_idx_r;
  logic [DATA_WIDTH-1:0] tok_match_data_r;
  logic [USES_W-1:0]     tok_best_uses_r;
  logic [STAMP_W-1:0]    tok_best_stamp_r;
  logic [IDX_W-1:0]      tok_best_idx_r;
  logic [KEY_WIDTH-1:0]  tok_best_key_r;

  logic slot_en;
  logic key_hit;
  logic better;
  logic wr_sel;

  assign slot_en = CNT_W'(IDX) < fill_cnt;
  assign key_hit = slot_en && !t_flags.match && (key_r == t_key);
  assign better  = slot_en && (!t_flags.best_vld || (uses_r < t_best_uses) ||
                   ((uses_r == t_best_uses) && (stamp_r < t_best_stamp)));
  assign wr_sel  = wr_ctl.we && (wr_idx == IDX_W'(IDX));

  // advance the search word one slot
  always_ff @(posedge clk) begin
    tok_key_r         <= t_key;
    tok_flags_r.match <= t_flags.match || key_hit;
    tok_match_idx_r   <= key_hit ? IDX_W'(IDX) : t_match_idx;
    tok_match_data_r  <= key_hit ? data_r : t_match_data;
    tok_flags_r.best_vld <= t_flags.best_vld || better;
    tok_best_uses_r   <= better ? uses_r : t_best_uses;
    tok_best_stamp_r  <= better ? stamp_r : t_best_stamp;
    tok_best_idx_r    <= better ? IDX_W'(IDX) : t_best_idx;
    tok_best_key_r    <= better ? key_r : t_best_key;
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      unique case (wr_ctl.kind)
        WR_TOUCH: begin
          if (uses_r != USES_MAX) begin
            uses_r <= uses_r + USES_ONE;
          end
          stamp_r <= wr_stamp;
          if (wr_ctl.upd_data) begin
            data_r <= wr_data;
          end
        end
        WR_LOAD: begin
          key_r   <= wr_key;
          data_r  <= wr_data;
          uses_r  <= USES_ONE;
          stamp_r <= wr_stamp;
        end
        default: begin
        end
      endcase
    end
  end

  assign o_key        = tok_key_r;
  assign o_flags      = tok_flags_r;
  assign o_match_idx  = tok_match_idx_r;
  assign o_match_data = tok_match_data_r;
  assign o_best_uses  = tok_best_uses_r;
  assign o_best_stamp = tok_best_stamp_r;
  assign o_best_idx   = tok_best_idx_r;
  assign o_best_key   = tok_best_key_r;

endmodule

### rtl/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with LRU tie break: control and slot chain.
// Depends on lfuc_pkg and lfuc_cell.
//
//   channel  ports                                            handshake
//   input    in_op, in_key, in_value                          start & !busy
//   result   out_hit, out_read_value, out_evicted, out_evicted_key   out_strobe, 1 cycle
//   config   cfg_wdata                                        cfg_we
//
// An access is latched on accept, then the search word walks the CAPACITY slots of the
// chain in ST_SCAN, and ST_WRITE writes back; busy stays high until write-back is done.
// The result strobe comes in the cycle after write-back, when busy is already low.
// With the capacity setting (cap_r) zero the result strobes in the cycle after accept.
// Reset empties the cache, clears the access clock and sets capacity to 16.
// The receiver cannot stall; every result is presented once.
module lfu_cache_lru_tiebreak #(
  parameter int CAPACITY   = 16,
  parameter int KEY_WIDTH  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [KEY_WIDTH-1:0]       in_key,
  input  logic [DATA_WIDTH-1:0]      in_value,
  output logic                       out_strobe,
  output logic                       out_hit,
  output logic [DATA_WIDTH-1:0]      out_read_value,
  output logic                       out_evicted,
  output logic [KEY_WIDTH-1:0]       out_evicted_key,
  input  logic                       cfg_we,
  input  logic [lfuc_pkg::CFG_W-1:0] cfg_wdata
);
  import lfuc_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     cap_r;
  logic [CNT_W-1:0]     filled_r;
  logic [STAMP_W-1:0]   clock_r;
  logic [IDX_W-1:0]     cnt_r;
  logic                 out_strobe_r;

  logic                  op_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  hit_r;
  logic [DATA_WIDTH-1:0] rd_r;
  logic                  ev_r;
  logic [KEY_WIDTH-1:0]  evk_r;

  logic [KEY_WIDTH-1:0]  ch_key        [CAPACITY+1];
  scan_flags_t           ch_flags      [CAPACITY+1];
  logic [IDX_W-1:0]      ch_match_idx  [CAPACITY+1];
  logic [DATA_WIDTH-1:0] ch_match_data [CAPACITY+1];
  logic [USES_W-1:0]     ch_best_uses  [CAPACITY+1];
  logic [STAMP_W-1:0]    ch_best_stamp [CAPACITY+1];
  logic [IDX_W-1:0]      ch_best_idx   [CAPACITY+1];
  logic [KEY_WIDTH-1:0]  ch_best_key   [CAPACITY+1];

  wr_ctl_t               wr_ctl;
  logic [IDX_W-1:0]      wr_idx;

  logic                  accept;
  logic                  has_room;
  logic                  res_hit;
  logic [DATA_WIDTH-1:0] res_rd;
  logic                  res_ev;
  logic [KEY_WIDTH-1:0]  res_evk;
  logic                  adv;
  logic                  fill_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // seed the search word
  assign ch_key[0]        = key_r;
  assign ch_flags[0]      = '0;
  assign ch_match_idx[0]  = '0;
  assign ch_match_data[0] = '0;
  assign ch_best_uses[0]  = '0;
  assign ch_best_stamp[0] = '0;
  assign ch_best_idx[0]   = '0;
  assign ch_best_key[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    lfuc_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk          (clk),
      .fill_cnt     (filled_r),
      .t_key        (ch_key[g]),
      .t_flags      (ch_flags[g]),
      .t_match_idx  (ch_match_idx[g]),
      .t_match_data (ch_match_data[g]),
      .t_best_uses  (ch_best_uses[g]),
      .t_best_stamp (ch_best_stamp[g]),
      .t_best_idx   (ch_best_idx[g]),
      .t_best_key   (ch_best_key[g]),
      .o_key        (ch_key[g+1]),
      .o_flags      (ch_flags[g+1]),
      .o_match_idx  (ch_match_idx[g+1]),
      .o_match_data (ch_match_data[g+1]),
      .o_best_uses  (ch_best_uses[g+1]),
      .o_best_stamp (ch_best_stamp[g+1]),
      .o_best_idx   (ch_best_idx[g+1]),
      .o_best_key   (ch_best_key[g+1]),
      .wr_ctl       (wr_ctl),
      .wr_idx       (wr_idx),
      .wr_key       (key_r),
      .wr_data      (val_r),
      .wr_stamp     (clock_r)
    );
  end

  assign has_room = (CW'(filled_r) < CW'(cap_r)) && (CW'(filled_r) < CW'(CAPACITY));

  always_comb begin
    wr_ctl   = '{we: 1'b0, kind: WR_TOUCH, upd_data: 1'b0};
    wr_idx   = ch_match_idx[CAPACITY];
    res_hit  = 1'b0;
    res_rd   = '0;
    res_ev   = 1'b0;
    res_evk  = '0;
    adv      = 1'b0;
    fill_inc = 1'b0;
    if (state_r == ST_WRITE) begin
      if (ch_flags[CAPACITY].match) begin
        wr_ctl  = '{we: 1'b1, kind: WR_TOUCH, upd_data: op_r};
        res_hit = 1'b1;
        res_rd  = op_r ? '0 : ch_match_data[CAPACITY];
        adv     = 1'b1;
      end else if (op_r) begin
        wr_ctl = '{we: 1'b1, kind: WR_LOAD, upd_data: 1'b1};
        adv    = 1'b1;
        if (has_room) begin
          wr_idx   = filled_r[IDX_W-1:0];
          fill_inc = 1'b1;
        end else begin
          wr_idx  = ch_best_idx[CAPACITY];
          res_ev  = 1'b1;
          res_evk = ch_best_key[CAPACITY];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      filled_r     <= '0;
      clock_r      <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      out_strobe_r <= (state_r == ST_WRITE) || (accept && (cap_r == '0));
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (cap_r != '0)) begin
            cnt_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(CAPACITY - 1)) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (adv) begin
            clock_r <= clock_r + STAMP_W'(1);
          end
          if (fill_inc) begin
            filled_r <= filled_r + CNT_W'(1);
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the word and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (accept || state_r == ST_WRITE) begin
      hit_r <= res_hit;
      rd_r  <= res_rd;
      ev_r  <= res_ev;
      evk_r <= res_evk;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_hit         = hit_r;
  assign out_read_value  = rd_r;
  assign out_evicted     = ev_r;
  assign out_evicted_key = evk_r;

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(filled_r) <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_evicted |-> !out_hit)
    else $error("eviction reported on a hit");

  a_write_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> out_strobe && !busy)
    else $error("write-back not followed by result");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cap_r != '0 |=> state_r == ST_SCAN && !out_strobe)
    else $error("enabled access did not start a scan");

endmodule

### bench/testbench.sv
// Self-checking bench for lfu_cache_lru_tiebreak: directed table, then random accesses.
// Predicts each get/put with its own LFU/LRU cache copy and checks every result word.
// Depends on lfuc_pkg and the lfu_cache_lru_tiebreak RTL.
module testbench;
  import lfuc_pkg::*;

  localparam int KW = 16;
  localparam int DW = 32;
  localparam int SLOTS = 16;
  localparam int POOL = 24;
  localparam int LIMIT = 400000;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] read_value;
    logic          evicted;
    logic [KW-1:0] evicted_key;
  } cache_word_t;

  typedef struct {
    row_kind_t     kind;
    logic          op;
    logic [KW-1:0] key;
    logic [DW-1:0] value;
    logic          typed;
    cache_word_t   want;
  } stim_row_t;

  localparam cache_word_t MISS = '0;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_op;
  logic [KW-1:0] in_key;
  logic [DW-1:0] in_value;
  logic out_strobe;
  logic out_hit;
  logic [DW-1:0] out_read_value;
  logic out_evicted;
  logic [KW-1:0] out_evicted_key;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lfu_cache_lru_tiebreak uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key), .in_value(in_value),
    .out_strobe(out_strobe), .out_hit(out_hit), .out_read_value(out_read_value),
    .out_evicted(out_evicted), .out_evicted_key(out_evicted_key),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [KW-1:0]      cached_key [SLOTS];
  logic [DW-1:0]      cached_data [SLOTS];
  logic [USES_W-1:0]  cached_uses [SLOTS];
  logic [STAMP_W-1:0] cached_stamp [SLOTS];
  int                 fill_count;
  logic [STAMP_W-1:0] tick_count;
  logic [CFG_W-1:0]   cap_setting;

  cache_word_t expected_words[$];
  stim_row_t   script[$];
  logic [KW-1:0] key_pool [POOL];
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function void bump_entry(input int idx);
    if (cached_uses[idx] != USES_MAX) cached_uses[idx] = cached_uses[idx] + USES_ONE;
    cached_stamp[idx] = tick_count;
  endfunction

  function void load_entry(input int idx, input logic [KW-1:0] key, input logic [DW-1:0] value);
    cached_key[idx] = key;
    cached_data[idx] = value;
    cached_uses[idx] = USES_ONE;
    cached_stamp[idx] = tick_count;
  endfunction

  function cache_word_t predict_access(input logic op, input logic [KW-1:0] key,
                                       input logic [DW-1:0] value);
    cache_word_t w;
    int lim;
    int found;
    int victim;
    w = MISS;
    lim = (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
    if (lim == 0) return w;
    found = -1;
    for (int i = 0; i < fill_count; i++) begin
      if (found < 0 && cached_key[i] == key) found = i;
    end
    if (op == OP_GET) begin
      if (found >= 0) begin
        w.hit = 1'b1;
        w.read_value = cached_data[found];
        bump_entry(found);
        tick_count = tick_count + STAMP_W'(1);
      end
      return w;
    end
    if (found >= 0) begin
      w.hit = 1'b1;
      cached_data[found] = value;
      bump_entry(found);
    end else if (fill_count < lim) begin
      load_entry(fill_count, key, value);
      fill_count = fill_count + 1;
    end else begin
      victim = 0;
      for (int i = 1; i < fill_count; i++) begin
        if (cached_uses[i] < cached_uses[victim] ||
            (cached_uses[i] == cached_uses[victim] && cached_stamp[i] < cached_stamp[victim]))
          victim = i;
      end
      w.evicted = 1'b1;
      w.evicted_key = cached_key[victim];
      load_entry(victim, key, value);
    end
    tick_count = tick_count + STAMP_W'(1);
    return w;
  endfunction

  task automatic send_word(input logic op, input logic [KW-1:0] key, input logic [DW-1:0] value,
                           input logic typed, input cache_word_t want);
    cache_word_t w;
    start <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (busy);
    w = predict_access(op, key, value);
    expected_words.push_back(typed ? want : w);
  endtask

  task automatic hold_off(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = cap;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    cache_word_t got;
    cache_word_t want;
    if (rst_n && out_strobe) begin
      got = {out_hit, out_read_value, out_evicted, out_evicted_key};
      if (expected_words.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected word: hit=%0b read=%h evicted=%0b key=%h",
                   got.hit, got.read_value, got.evicted, got.evicted_key);
      end else begin
        want = expected_words.pop_front();
        if (got.hit !== want.hit || got.read_value !== want.read_value ||
            got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: want hit=%0b read=%h evicted=%0b key=%h, ",
                      "got hit=%0b read=%h evicted=%0b key=%h"},
                     want.hit, want.read_value, want.evicted, want.evicted_key,
                     got.hit, got.read_value, got.evicted, got.evicted_key);
        end
      end
    end
  end

  initial begin
    int phase_cap [6];
    int phase_idle [6];
    int phase_items [6];
    logic op;
    logic [KW-1:0] key;
    logic [DW-1:0] value;
    phase_cap = '{16, 1, 0, 31, 5, 16};
    phase_idle = '{16, 16, 57, 57, 0, 0};
    phase_items = '{450, 120, 20, 330, 200, 200};
    mismatches = 0;
    cycles = 0;
    fill_count = 0;
    tick_count = '0;
    cap_setting = CAP_RESET;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_GET;
    in_key <= '0;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) key_pool[i] = KW'($urandom);

    script.push_back('{ROW_WORD, OP_GET, 16'h0000, 32'h0, 1'b1, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h0000, 32'hFFFF_FFFF, 1'b1, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h0000, 32'h0, 1'b1,
                       {1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0}});
    script.push_back('{ROW_WORD, OP_PUT, 16'hFFFF, 32'h0, 1'b1, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'hFFFF, 32'h1234, 1'b1,
                       {1'b1, 32'h0, 1'b0, 16'h0}});
    script.push_back('{ROW_WORD, OP_PUT, 16'hFFFF, 32'hA5A5_5A5A, 1'b1,
                       {1'b1, 32'h0, 1'b0, 16'h0}});
    script.push_back('{ROW_WORD, OP_GET, 16'hFFFF, 32'h0, 1'b1,
                       {1'b1, 32'hA5A5_5A5A, 1'b0, 16'h0}});
    script.push_back('{ROW_CFG, OP_GET, 16'h0, 32'd0, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h0000, 32'h0, 1'b1, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h1234, 32'hDEAD_BEEF, 1'b1, MISS});
    script.push_back('{ROW_CFG, OP_GET, 16'h0, 32'd1, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h1234, 32'h1, 1'b1,
                       {1'b0, 32'h0, 1'b1, 16'h0000}});
    script.push_back('{ROW_WORD, OP_GET, 16'h0000, 32'h0, 1'b1, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h1234, 32'h0, 1'b1,
                       {1'b1, 32'h1, 1'b0, 16'h0}});
    script.push_back('{ROW_CFG, OP_GET, 16'h0, 32'd31, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h0001, 32'h1234_5678, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h0002, 32'h8765_4321, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h0001, 32'h0, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h0002, 32'h0, 1'b0, MISS});
    script.push_back('{ROW_CFG, OP_GET, 16'h0, 32'd4, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h8000, 32'h5555_AAAA, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h7FFF, 32'hAAAA_5555, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_PUT, 16'h4000, 32'h0F0F_F0F0, 1'b0, MISS});
    script.push_back('{ROW_WORD, OP_GET, 16'h8000, 32'h0, 1'b0, MISS});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_capacity(CFG_W'(script[i].value));
      end else begin
        send_word(script[i].op, script[i].key, script[i].value, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      write_capacity(CFG_W'(phase_cap[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        hold_off(phase_idle[p]);
        op = 1'($urandom_range(1));
        key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL - 1)] : KW'($urandom);
        case ($urandom_range(9))
          0: value = '0;
          1: value = '1;
          default: value = DW'($urandom);
        endcase
        send_word(op, key, value, 1'b0, MISS);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
